>>> sv/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types, constants and lead-byte decode shared by the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam logic [15:0] QMARK      = 16'h003F;
  localparam logic [15:0] HI_SURR    = 16'hD800;
  localparam logic [15:0] HI_SURR_MX = 16'hDBFF;
  localparam logic [5:0]  LO_SURR_HI = 6'b110111;
  localparam logic [25:0] SUPP_BASE  = 26'h0010000;

  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_4 = 3'd4;
  localparam logic [2:0] LEN_5 = 3'd5;
  localparam logic [2:0] LEN_6 = 3'd6;

  localparam int unsigned OBUF_DEPTH = 4;
  localparam int unsigned OBUF_AW    = $clog2(OBUF_DEPTH);
  localparam int unsigned OBUF_CW    = $clog2(OBUF_DEPTH + 1);

  typedef struct packed {
    logic        emit;
    logic [15:0] unit;
    logic        open;
    logic [2:0]  len;
    logic [20:0] bits;
    logic        skip;
  } lead_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        cesu_seen;
    logic        run_end;
  } entry_t;

  typedef struct packed {
    logic [1:0]  cnt;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        cesu;
  } res_t;

  function automatic lead_t lead_decode(input logic [7:0] b);
    lead_t l;
    l = '0;
    if (b[7] == 1'b0) begin
      l.emit = 1'b1;
      l.unit = {8'h00, b};
    end else if (b[7:5] == 3'b110) begin
      l.open = 1'b1;
      l.len  = LEN_2;
      l.bits = {16'h0000, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      l.open = 1'b1;
      l.len  = LEN_3;
      l.bits = {17'h00000, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      l.open = 1'b1;
      l.len  = LEN_4;
      l.bits = {18'h00000, b[2:0]};
    end else if (b[7:2] == 6'b111110) begin
      l.open = 1'b1;
      l.len  = LEN_5;
      l.bits = {19'h00000, b[1:0]};
    end else if (b[7:1] == 7'b1111110) begin
      l.open = 1'b1;
      l.len  = LEN_6;
      l.bits = {20'h00000, b[0]};
    end else begin
      l.emit = 1'b1;
      l.unit = QMARK;
      l.skip = 1'b1;
    end
    return l;
  endfunction

endpackage

>>> sv/utf8_to_utf16_decoder.sv
// Path: the decode is combinational; the code units of an accepted byte are
// written into the result buffer, and the head entry drives the outputs.
// Throughput: one byte per cycle while in_tready is high; one code unit leaves
// per cycle while out_tready is high. Bytes giving two units (surrogate pairs,
// cut-short sequences) throttle input through the four-entry result buffer.
// Reset: synchronous active-low rst_n clears sequence state and the buffer.
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// UTF-8 bytes in, UTF-16 code units out, one byte per cycle while in_tready.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] code_unit
  output logic [0:0]  out_tuser,  // [0] cesu_seen
  output logic        out_tlast   // run_end
);

  logic                fire;
  u8u16_pkg::res_t     res;
  u8u16_pkg::entry_t   head;

  assign fire = in_tvalid && in_tready;

  u8u16_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .text_byte  (in_tdata),
    .final_byte (in_tlast),
    .res        (res)
  );

  u8u16_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fire),
    .res      (res),
    .room     (in_tready),
    .rd_valid (out_tvalid),
    .rd_en    (out_tready),
    .rd_data  (head)
  );

  assign out_tdata = head.code_unit;
  assign out_tuser = head.cesu_seen;
  assign out_tlast = head.run_end;

endmodule

>>> sv/u8u16_core.sv
// ----------------------------------------------------------------------------
// u8u16_core
// Sequence state and per-byte decode; yields up to two code units a byte.
// ----------------------------------------------------------------------------
module u8u16_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          text_byte,
  input  logic                final_byte,
  output u8u16_pkg::res_t     res
);

  logic [2:0]  exp_r, exp_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic [20:0] code_r, code_nxt;
  logic        skip_r, skip_nxt;
  logic        cesu_r, cesu_nxt;

  logic              cont;
  logic [20:0]       code_sh;
  logic [25:0]       supp;
  u8u16_pkg::lead_t  lead;
  u8u16_pkg::res_t   r;

  always_comb begin
    exp_nxt  = exp_r;
    rem_nxt  = rem_r;
    code_nxt = code_r;
    skip_nxt = skip_r;
    cesu_nxt = cesu_r;
    r        = '0;
    r.unit0  = u8u16_pkg::QMARK;
    r.unit1  = u8u16_pkg::QMARK;
    cont     = (text_byte[7:6] == 2'b10);
    code_sh  = {code_r[14:0], text_byte[5:0]};
    supp     = {5'b00000, code_sh} - u8u16_pkg::SUPP_BASE;
    lead     = u8u16_pkg::lead_decode(text_byte);

    if (rem_r != 3'd0) begin
      if (cont) begin
        rem_nxt  = rem_r - 3'd1;
        code_nxt = code_sh;
        if (rem_r == 3'd1) begin
          exp_nxt  = 3'd0;
          code_nxt = '0;
          r.cnt    = 2'd1;
          unique case (exp_r)
            u8u16_pkg::LEN_2: r.unit0 = {5'b00000, code_sh[10:0]};
            u8u16_pkg::LEN_3: begin
              r.unit0 = code_sh[15:0];
              if (code_sh[15:0] >= u8u16_pkg::HI_SURR &&
                  code_sh[15:0] <= u8u16_pkg::HI_SURR_MX) begin
                cesu_nxt = 1'b1;
              end
            end
            u8u16_pkg::LEN_4: begin
              r.cnt   = 2'd2;
              r.unit0 = supp[25:10] + u8u16_pkg::HI_SURR;
              r.unit1 = {u8u16_pkg::LO_SURR_HI, supp[9:0]};
            end
            default: r.unit0 = u8u16_pkg::QMARK;
          endcase
        end
      end else begin
        r.cnt    = 2'd1;
        exp_nxt  = 3'd0;
        rem_nxt  = 3'd0;
        code_nxt = '0;
        if (lead.emit) begin
          r.cnt   = 2'd2;
          r.unit1 = lead.unit;
        end
        if (lead.open) begin
          exp_nxt  = lead.len;
          rem_nxt  = lead.len - 3'd1;
          code_nxt = lead.bits;
        end
        if (lead.skip) begin
          skip_nxt = 1'b1;
        end
      end
    end else if (!(skip_r && cont)) begin
      skip_nxt = lead.skip;
      if (lead.emit) begin
        r.cnt   = 2'd1;
        r.unit0 = lead.unit;
      end
      if (lead.open) begin
        exp_nxt  = lead.len;
        rem_nxt  = lead.len - 3'd1;
        code_nxt = lead.bits;
      end
    end

    if (final_byte) begin
      if (rem_nxt != 3'd0) begin
        if (r.cnt == 2'd0) begin
          r.unit0 = u8u16_pkg::QMARK;
        end else begin
          r.unit1 = u8u16_pkg::QMARK;
        end
        r.cnt = r.cnt + 2'd1;
      end
      exp_nxt  = 3'd0;
      rem_nxt  = 3'd0;
      code_nxt = '0;
      skip_nxt = 1'b0;
    end

    r.cesu = cesu_nxt;
    if (final_byte) begin
      cesu_nxt = 1'b0;
    end
    res = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= '0;
      rem_r  <= '0;
      code_r <= '0;
      skip_r <= 1'b0;
      cesu_r <= 1'b0;
    end else if (fire) begin
      exp_r  <= exp_nxt;
      rem_r  <= rem_nxt;
      code_r <= code_nxt;
      skip_r <= skip_nxt;
      cesu_r <= cesu_nxt;
    end
  end

`ifndef SYNTH
  a_rem_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != 3'd0) |-> (exp_r > rem_r))
    else $error("remaining count not below sequence length");
  a_skip_idle: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> (rem_r == 3'd0))
    else $error("skipping while a sequence is open");
`endif

endmodule

>>> sv/u8u16_obuf.sv
// ----------------------------------------------------------------------------
// u8u16_obuf
// Result buffer: takes up to two units a cycle, gives one a cycle while rd_en.
// ----------------------------------------------------------------------------
module u8u16_obuf (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  u8u16_pkg::res_t                     res,
  output logic                                room,
  output logic                                rd_valid,
  input  logic                                rd_en,
  output u8u16_pkg::entry_t                   rd_data
);

  u8u16_pkg::entry_t                    mem_r [u8u16_pkg::OBUF_DEPTH];
  logic [u8u16_pkg::OBUF_AW-1:0]        wp_r, wp_nxt;
  logic [u8u16_pkg::OBUF_AW-1:0]        rp_r, rp_nxt;
  logic [u8u16_pkg::OBUF_CW-1:0]        cnt_r, cnt_nxt;
  logic [1:0]                           n_wr;
  logic                                 pop;

  assign n_wr     = wr_en ? res.cnt : 2'd0;
  assign pop      = rd_en && rd_valid;
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign room     = (cnt_r <= u8u16_pkg::OBUF_CW'(u8u16_pkg::OBUF_DEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + u8u16_pkg::OBUF_AW'(n_wr);
    rp_nxt  = rp_r + u8u16_pkg::OBUF_AW'(pop);
    cnt_nxt = cnt_r + u8u16_pkg::OBUF_CW'(n_wr) - u8u16_pkg::OBUF_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      mem_r[wp_r] <= '{code_unit: res.unit0, cesu_seen: res.cesu,
                       run_end: (n_wr == 2'd1)};
    end
    if (n_wr == 2'd2) begin
      mem_r[wp_r + u8u16_pkg::OBUF_AW'(1)] <= '{code_unit: res.unit1,
                                               cesu_seen: res.cesu, run_end: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= u8u16_pkg::OBUF_CW'(u8u16_pkg::OBUF_DEPTH))
    else $error("result buffer overflow");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> cnt_r == $past(cnt_r) + u8u16_pkg::OBUF_CW'($past(n_wr))
                      - u8u16_pkg::OBUF_CW'($past(pop)))
    else $error("result count out of step with writes and reads");
`endif

endmodule

>>> test/utf8_to_utf16_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_tb
// Streams UTF-8 text into the decoder: a short directed set, then mostly
// well-formed random sequences mixed with noise, cut-short runs and stray
// bytes. Each accepted byte is decoded by a local model into the code units
// it should give, and every unit leaving the block is checked against them.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_tb;

  localparam logic [15:0] LO_SURR_BASE   = 16'hDC00;
  localparam logic [31:0] SUPP_OFFSET    = 32'h0001_0000;
  localparam int          RANDOM_BYTES   = 450;
  localparam int          HOLD_AFTER     = 120;
  localparam int          HOLD_CYCLES    = 60;
  localparam int          DRAIN_AT       = 300;
  localparam int          QUIET_TAIL     = 60;
  localparam int          WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [7:0] text;
    logic       fin;
    logic       drain;
  } text_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        cesu_seen;
    logic        run_end;
  } unit_rec_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;

  text_item_t  text_q[$];
  unit_rec_t   pending_units[$];
  logic [15:0] new_units[$];
  int          n_items;
  int          n_errors = 0;
  logic        results_pending = 1'b0;

  // decoder model state
  logic [2:0]  seq_len;
  logic [2:0]  seq_left;
  logic [20:0] seq_bits;
  logic        skip_cont;
  logic        cesu_sticky;

  utf8_to_utf16_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  task automatic open_char(input logic [2:0] len, input logic [20:0] bits);
    seq_len  = len;
    seq_left = len - 3'd1;
    seq_bits = bits;
  endtask

  task automatic start_char(input logic [7:0] b);
    if (b[7] == 1'b0) begin
      new_units.push_back({8'h00, b});
    end else if (b[7:5] == 3'b110) begin
      open_char(u8u16_pkg::LEN_2, {16'h0, b[4:0]});
    end else if (b[7:4] == 4'b1110) begin
      open_char(u8u16_pkg::LEN_3, {17'h0, b[3:0]});
    end else if (b[7:3] == 5'b11110) begin
      open_char(u8u16_pkg::LEN_4, {18'h0, b[2:0]});
    end else if (b[7:2] == 6'b111110) begin
      open_char(u8u16_pkg::LEN_5, {19'h0, b[1:0]});
    end else if (b[7:1] == 7'b1111110) begin
      open_char(u8u16_pkg::LEN_6, {20'h0, b[0]});
    end else begin
      new_units.push_back(u8u16_pkg::QMARK);
      skip_cont = 1'b1;
    end
  endtask

  task automatic close_char();
    logic [31:0] supp;
    logic [31:0] half;
    case (seq_len)
      u8u16_pkg::LEN_2: begin
        new_units.push_back({5'h00, seq_bits[10:0]});
      end
      u8u16_pkg::LEN_3: begin
        if (seq_bits[15:0] >= u8u16_pkg::HI_SURR && seq_bits[15:0] <= u8u16_pkg::HI_SURR_MX)
          cesu_sticky = 1'b1;
        new_units.push_back(seq_bits[15:0]);
      end
      u8u16_pkg::LEN_4: begin
        // wraps for overlong codes below the supplementary range
        supp = {11'h000, seq_bits} - SUPP_OFFSET;
        half = (supp >> 10) + {16'h0000, u8u16_pkg::HI_SURR};
        new_units.push_back(half[15:0]);
        half = (supp & 32'h0000_03FF) + {16'h0000, LO_SURR_BASE};
        new_units.push_back(half[15:0]);
      end
      default: begin
        new_units.push_back(u8u16_pkg::QMARK);
      end
    endcase
    seq_len  = 3'd0;
    seq_bits = 21'h0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic      cont;
    unit_rec_t rec;
    cont = (b[7:6] == 2'b10);
    new_units.delete();
    if (seq_left != 3'd0) begin
      if (cont) begin
        seq_bits = {seq_bits[14:0], b[5:0]};
        seq_left = seq_left - 3'd1;
        if (seq_left == 3'd0)
          close_char();
      end else begin
        // sequence cut short, byte handled afresh
        new_units.push_back(u8u16_pkg::QMARK);
        seq_left = 3'd0;
        seq_len  = 3'd0;
        seq_bits = 21'h0;
        start_char(b);
      end
    end else if (skip_cont && cont) begin
      // continuation after a bad lead is dropped
    end else begin
      skip_cont = 1'b0;
      start_char(b);
    end
    if (fin) begin
      if (seq_left != 3'd0)
        new_units.push_back(u8u16_pkg::QMARK);
      seq_left  = 3'd0;
      seq_len   = 3'd0;
      seq_bits  = 21'h0;
      skip_cont = 1'b0;
    end
    foreach (new_units[k]) begin
      rec.code_unit = new_units[k];
      rec.cesu_seen = cesu_sticky;
      rec.run_end   = (k == new_units.size() - 1);
      pending_units.push_back(rec);
    end
    if (fin)
      cesu_sticky = 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic queue_byte(input logic [7:0] b, input logic fin);
    text_item_t it;
    it.text  = b;
    it.fin   = fin;
    it.drain = 1'b0;
    text_q.push_back(it);
  endtask

  function automatic logic [7:0] cont_byte();
    logic [5:0] payload;
    payload = 6'($urandom_range(0, 63));
    return {2'b10, payload};
  endfunction

  task automatic queue_char(input int len, input int conts);
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    case (len)
      2:       queue_byte({3'b110, r[4:0]}, 1'b0);
      3:       queue_byte({4'b1110, r[3:0]}, 1'b0);
      4:       queue_byte({5'b11110, r[2:0]}, 1'b0);
      5:       queue_byte({6'b111110, r[1:0]}, 1'b0);
      default: queue_byte({7'b1111110, r[0]}, 1'b0);
    endcase
    repeat (conts) queue_byte(cont_byte(), 1'b0);
  endtask

  initial begin
    int          kind;
    int          len;
    logic [31:0] r;
    text_item_t  it;

    // ascii extremes
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b0);
    // two-byte
    queue_byte(8'hC2, 1'b0); queue_byte(8'hA9, 1'b0);
    // three-byte landing in the high surrogate range sets the cesu flag
    queue_byte(8'hED, 1'b0); queue_byte(8'hA0, 1'b0); queue_byte(8'h80, 1'b0);
    // four-byte surrogate pair
    queue_byte(8'hF0, 1'b0); queue_byte(8'h9F, 1'b0);
    queue_byte(8'h98, 1'b0); queue_byte(8'h80, 1'b0);
    // overlong four-byte wraps, ends the text and clears the flag
    queue_byte(8'hF0, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'h80, 1'b0); queue_byte(8'h80, 1'b1);
    // six-byte gives one replacement
    queue_byte(8'hFC, 1'b0);
    repeat (5) queue_byte(8'h80, 1'b0);
    // bad lead, then continuations dropped, the last one ending the text
    queue_byte(8'hFF, 1'b0); queue_byte(8'h80, 1'b0); queue_byte(8'hBF, 1'b1);
    // sequence interrupted by ascii
    queue_byte(8'hE2, 1'b0); queue_byte(8'h41, 1'b0);
    // five-byte lead cut short by end of text
    queue_byte(8'hF8, 1'b1);

    while (text_q.size() < RANDOM_BYTES + 27) begin
      kind = $urandom_range(0, 15);
      r    = $urandom;
      case (kind)
        0, 1, 2: queue_byte({1'b0, r[6:0]}, 1'b0);
        3, 4:    queue_char(2, 1);
        5:       queue_char(3, 2);
        6: begin
          queue_byte(8'hED, 1'b0);
          queue_byte({3'b101, r[4:0]}, 1'b0);
          queue_byte(cont_byte(), 1'b0);
        end
        7, 8:    queue_char(4, 3);
        9: begin
          len = $urandom_range(5, 6);
          queue_char(len, len - 1);
        end
        10, 11: begin
          len = $urandom_range(2, 6);
          queue_char(len, $urandom_range(0, len - 2));
        end
        12: begin
          if (r[8])
            queue_byte({2'b10, r[5:0]}, 1'b0);
          else
            queue_byte({7'b1111111, r[0]}, 1'b0);
          repeat ($urandom_range(0, 3)) queue_byte(cont_byte(), 1'b0);
        end
        default: queue_byte(r[7:0], 1'b0);
      endcase
      if ($urandom_range(0, 11) == 0) begin
        it = text_q.pop_back();
        it.fin = 1'b1;
        text_q.push_back(it);
      end
    end
    it = text_q[DRAIN_AT];
    it.drain = 1'b1;
    text_q[DRAIN_AT] = it;
    n_items = text_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (text_q.size() != 0 || in_tvalid || pending_units.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);

    if (pending_units.size() != 0)
      $error("%0d code units never arrived", pending_units.size());
    if (n_errors == 0 && pending_units.size() == 0) begin
      $display("utf8_to_utf16_decoder_tb: done, clean");
    end else begin
      $display("utf8_to_utf16_decoder_tb: done, errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  int send_gap = 0;

  always @(posedge clk) begin
    int  sent;
    logic calm;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tlast  <= 1'b0;
      send_gap  = 0;
    end else if (!in_tvalid || in_tready) begin
      sent = n_items - text_q.size();
      calm = (text_q.size() < QUIET_TAIL) || ((sent / 40) % 4 == 1);
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (text_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (text_q[0].drain && (in_tvalid || results_pending)) begin
        // pause until the block has handed back everything
        in_tvalid <= 1'b0;
      end else begin
        in_tdata  <= text_q[0].text;
        in_tlast  <= text_q[0].fin;
        in_tvalid <= 1'b1;
        void'(text_q.pop_front());
        if (!calm && $urandom_range(0, 5) == 0)
          send_gap = $urandom_range(1, 7);
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  int rx_bytes   = 0;
  int stall_left = 0;
  int hold_left  = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    logic calm;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_bytes   = 0;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        rx_bytes++;
      calm = (rx_bytes + QUIET_TAIL >= n_items) || ((rx_bytes / 50) % 3 == 1);
      if (!hold_done && rx_bytes >= HOLD_AFTER) begin
        // long back-pressure so the result buffer fills and input stalls
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    unit_rec_t want;
    if (!rst_n) begin
      seq_len     = 3'd0;
      seq_left    = 3'd0;
      seq_bits    = 21'h0;
      skip_cont   = 1'b0;
      cesu_sticky = 1'b0;
      pending_units.delete();
      results_pending <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_units.size() == 0) begin
          $error("unexpected code unit %h", out_tdata);
          n_errors++;
        end else begin
          want = pending_units.pop_front();
          if (out_tdata !== want.code_unit) begin
            $error("code_unit: expected %h, got %h", want.code_unit, out_tdata);
            n_errors++;
          end
          if (out_tuser[0] !== want.cesu_seen) begin
            $error("cesu_seen: expected %b, got %b", want.cesu_seen, out_tuser[0]);
            n_errors++;
          end
          if (out_tlast !== want.run_end) begin
            $error("run_end: expected %b, got %b", want.run_end, out_tlast);
            n_errors++;
          end
        end
      end
      if (in_tvalid && in_tready)
        decode_byte(in_tdata, in_tlast);
      results_pending <= (pending_units.size() != 0);
    end
  end

  // ---------------------------------------------------------------- watchdog

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("utf8_to_utf16_decoder_tb: done, errors");
        $finish;
      end
    end
  end

endmodule
